FILE: rtl/core/keyframe_vertex_normal_interpolator_assert.svh
// Assertion macros used by the keyframe vertex interpolator top level.
`ifndef KEYFRAME_VERTEX_NORMAL_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_VERTEX_NORMAL_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KVNI_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KVNI_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/kvni_pkg.sv
// Types and constants shared by the keyframe vertex interpolator modules.
`timescale 1ns / 1ps
`default_nettype none

package kvni_pkg;

  // Q1.16 weight of 1.0
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] cur_z;
    logic signed [15:0] nxt_x;
    logic signed [15:0] nxt_y;
    logic signed [15:0] nxt_z;
    logic [7:0]         cur_theta;
    logic [7:0]         cur_phi;
    logic [7:0]         nxt_theta;
    logic [7:0]         nxt_phi;
  } in_t;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } out_t;

  // sine and cosine, Q1.14
  typedef struct packed {
    logic signed [15:0] sin_q;
    logic signed [15:0] cos_q;
  } trig_t;

  // one frame's coordinates, 1/64 units
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } coord3_t;

  // one frame's normal, Q2.28
  typedef struct packed {
    logic signed [29:0] x;
    logic signed [29:0] y;
    logic signed [29:0] z;
  } norm3_t;

  // per-stage advance enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

`default_nettype wire

FILE: rtl/core/kvni_angle_rom.sv
// Angle code to sine/cosine lookup table, built at elaboration.
`timescale 1ns / 1ps
`default_nettype none

module kvni_angle_rom #(
  parameter int ANGLE_STEPS = 256
) (
  input  var logic [7:0]      code,
  output kvni_pkg::trig_t     trig
);

  localparam int          ANGLE_MAX   = ANGLE_STEPS - 1;
  localparam int          ANGLE_CODES = 256;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Q2.30 to Q1.14, clamped to [0, 1], round to nearest
  function automatic logic signed [15:0] q30_to_q14(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic [63:0]        u;
    t = v;
    if (t < 0) begin
      t = 64'sd0;
    end
    if (t > 64'sd1073741824) begin
      t = 64'sd1073741824;
    end
    u = ($unsigned(t) + 64'd32768) >> 16;
    return u[15:0];
  endfunction

  // {sin, cos} for one angle code
  function automatic logic [31:0] trig_entry(input int code_i);
    logic [63:0]        e, q, r, x, x2, term;
    logic signed [63:0] acc;
    logic signed [15:0] s, c, so, co;
    e  = (64'(code_i) * 64'(ANGLE_MAX) + 64'd127) / 64'd255;
    q  = (64'd4 * e) / 64'(ANGLE_MAX);
    r  = 64'd4 * e - q * 64'(ANGLE_MAX);
    x  = (r * HALF_PI_Q30) / 64'(ANGLE_MAX);
    x2 = (x * x) >> 30;
    // sine series
    term = x;
    acc  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; acc = acc + $signed(term);
    s = q30_to_q14(acc);
    // cosine series
    term = 64'd1 << 30;
    acc  = $signed(term);
    term = ((term * x2) >> 30) / 64'd2;   acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd12;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd30;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd56;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd90;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd132; acc = acc + $signed(term);
    c = q30_to_q14(acc);
    // quadrant fold
    case (q[1:0])
      2'd0: begin
        so = s;
        co = c;
      end
      2'd1: begin
        so = c;
        co = -s;
      end
      2'd2: begin
        so = -s;
        co = -c;
      end
      default: begin
        so = -c;
        co = s;
      end
    endcase
    return {so, co};
  endfunction

  function automatic logic [ANGLE_CODES*32-1:0] build_table();
    logic [ANGLE_CODES*32-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < ANGLE_CODES; i++) begin
      tbl[i*32 +: 32] = trig_entry(i);
    end
    return tbl;
  endfunction

  localparam logic [ANGLE_CODES*32-1:0] ANGLE_TABLE = build_table();

  assign trig = kvni_pkg::trig_t'(ANGLE_TABLE[{code, 5'd0} +: 32]);

endmodule

`default_nettype wire

FILE: rtl/core/kvni_normal_gen.sv
// Per-frame normal from registered sine/cosine, one register stage.
`timescale 1ns / 1ps
`default_nettype none

module kvni_normal_gen (
  input  var logic            clk,
  input  var logic            en,
  input  var kvni_pkg::trig_t theta,
  input  var kvni_pkg::trig_t phi,
  output kvni_pkg::norm3_t    n
);

  logic signed [31:0] px, py;

  // Q1.14 * Q1.14 -> Q2.28, magnitude <= 2^28
  assign px = phi.cos_q * theta.sin_q;
  assign py = phi.sin_q * theta.sin_q;

  always_ff @(posedge clk) begin
    if (en) begin
      n.x <= px[29:0];
      n.y <= py[29:0];
      n.z <= {theta.cos_q[15:0], 14'd0};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/kvni_blend.sv
// Weighted blend of positions and normals: product stage, then sum/round stage.
`timescale 1ns / 1ps
`default_nettype none

module kvni_blend (
  input  var logic               clk,
  input  var kvni_pkg::pipe_en_t en,
  input  var logic [16:0]        w,
  input  var logic [16:0]        wc,
  input  var kvni_pkg::coord3_t  c_cur,
  input  var kvni_pkg::coord3_t  c_nxt,
  input  var kvni_pkg::norm3_t   n_cur,
  input  var kvni_pkg::norm3_t   n_nxt,
  output kvni_pkg::out_t         out_data
);

  logic signed [17:0] ws, wcs;
  logic signed [15:0] cc [3];
  logic signed [15:0] cn [3];
  logic signed [29:0] nc [3];
  logic signed [29:0] nn [3];

  // stage 3 products
  logic signed [33:0] pp_cur [3];
  logic signed [33:0] pp_nxt [3];
  logic signed [45:0] np_cur [3];
  logic signed [45:0] np_nxt [3];

  // stage 4 results
  logic signed [19:0] pos_r  [3];
  logic signed [15:0] norm_r [3];

  assign ws  = $signed({1'b0, w});
  assign wcs = $signed({1'b0, wc});

  assign cc[0] = c_cur.x;
  assign cc[1] = c_cur.y;
  assign cc[2] = c_cur.z;
  assign cn[0] = c_nxt.x;
  assign cn[1] = c_nxt.y;
  assign cn[2] = c_nxt.z;
  assign nc[0] = n_cur.x;
  assign nc[1] = n_cur.y;
  assign nc[2] = n_cur.z;
  assign nn[0] = n_nxt.x;
  assign nn[1] = n_nxt.y;
  assign nn[2] = n_nxt.z;

  for (genvar k = 0; k < 3; k++) begin : g_comp
    logic signed [47:0] mc, mn;
    logic signed [34:0] psum;
    logic signed [46:0] nsum;

    assign mc = wcs * nc[k];
    assign mn = ws * nn[k];

    always_ff @(posedge clk) begin
      if (en.s3) begin
        pp_cur[k] <= wcs * cc[k];
        pp_nxt[k] <= ws * cn[k];
        np_cur[k] <= mc[45:0];
        np_nxt[k] <= mn[45:0];
      end
    end

    // floor for positions; normals round half up at bit 30
    assign psum = 35'(pp_cur[k]) + 35'(pp_nxt[k]);
    assign nsum = 47'(np_cur[k]) + 47'(np_nxt[k]) + 47'sd536870912;

    always_ff @(posedge clk) begin
      if (en.s4) begin
        pos_r[k]  <= psum[31:12];
        norm_r[k] <= nsum[45:30];
      end
    end
  end

  assign out_data.pos_x  = pos_r[0];
  assign out_data.pos_y  = pos_r[1];
  assign out_data.pos_z  = pos_r[2];
  assign out_data.norm_x = norm_r[0];
  assign out_data.norm_y = norm_r[1];
  assign out_data.norm_z = norm_r[2];

endmodule

`default_nettype wire

FILE: rtl/core/keyframe_vertex_normal_interpolator.sv
// Top level of the keyframe vertex interpolator with packed-angle normal decode.
`timescale 1ns / 1ps
`default_nettype none

// Blends one vertex between two keyframes per transaction. Positions come out
// in 1/1024 units as floor(((1-w)*cur + w*nxt) >> 12); each frame's normal is
// decoded from its theta/phi angle bytes through a sine/cosine table and
// blended with the same weight, rounded to nearest in Q1.14. The weight is
// written through blend_weight/blend_weight_we (Q1.16, values above 1.0 are
// clamped to 1.0) and must only be changed while no transaction is in flight.
// Throughput is one transaction per clock while out_stall is low. The
// accepting edge loads the first of four register stages (table lookup,
// per-frame normal products, weight products, sum/round), and out_valid is
// the valid flag of the last stage. The table is constant logic, so there is
// no initialization pass after reset. Stalls propagate back stage by stage, and
// empty stages fill even while out_stall is high, so in_stall only rises when
// all four stages hold data.

module keyframe_vertex_normal_interpolator #(
  parameter int ANGLE_STEPS = 256
) (
  input  var logic           clk,
  input  var logic           rst,
  input  var logic           in_valid,
  output logic               in_stall,
  input  var kvni_pkg::in_t  in_data,
  output logic               out_valid,
  input  var logic           out_stall,
  output kvni_pkg::out_t     out_data,
  input  var logic           blend_weight_we,
  input  var logic [16:0]    blend_weight
);

`include "keyframe_vertex_normal_interpolator_assert.svh"

  // Weight register, clamped on write; complement kept alongside.
  logic [16:0] w, wc, w_sat;

  assign w_sat = (blend_weight > kvni_pkg::ONE_Q16) ? kvni_pkg::ONE_Q16 : blend_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      w  <= '0;
      wc <= kvni_pkg::ONE_Q16;
    end else if (blend_weight_we) begin
      w  <= w_sat;
      wc <= kvni_pkg::ONE_Q16 - w_sat;
    end
  end

  // Pipeline control: a stage advances when it is empty or the next advances.
  logic v1, v2, v3, v4;
  kvni_pkg::pipe_en_t en;

  assign en.s4 = !v4 || !out_stall;
  assign en.s3 = !v3 || en.s4;
  assign en.s2 = !v2 || en.s3;
  assign en.s1 = !v1 || en.s2;

  assign in_stall  = !en.s1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= in_valid;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en.s4) begin
        v4 <= v3;
      end
    end
  end

  // Stage 1: angle table lookups, coordinates captured.
  kvni_pkg::trig_t   t_cur_th, t_cur_ph, t_nxt_th, t_nxt_ph;
  kvni_pkg::trig_t   r_cur_th, r_cur_ph, r_nxt_th, r_nxt_ph;
  kvni_pkg::coord3_t c1_cur, c1_nxt, c2_cur, c2_nxt;

  kvni_angle_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom_cur_th (
    .code (in_data.cur_theta),
    .trig (t_cur_th)
  );
  kvni_angle_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom_cur_ph (
    .code (in_data.cur_phi),
    .trig (t_cur_ph)
  );
  kvni_angle_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom_nxt_th (
    .code (in_data.nxt_theta),
    .trig (t_nxt_th)
  );
  kvni_angle_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom_nxt_ph (
    .code (in_data.nxt_phi),
    .trig (t_nxt_ph)
  );

  always_ff @(posedge clk) begin
    if (en.s1) begin
      r_cur_th <= t_cur_th;
      r_cur_ph <= t_cur_ph;
      r_nxt_th <= t_nxt_th;
      r_nxt_ph <= t_nxt_ph;
      c1_cur   <= '{x: in_data.cur_x, y: in_data.cur_y, z: in_data.cur_z};
      c1_nxt   <= '{x: in_data.nxt_x, y: in_data.nxt_y, z: in_data.nxt_z};
    end
  end

  // Stage 2: per-frame normals; coordinates ride along.
  kvni_pkg::norm3_t n_cur, n_nxt;

  kvni_normal_gen u_norm_cur (
    .clk   (clk),
    .en    (en.s2),
    .theta (r_cur_th),
    .phi   (r_cur_ph),
    .n     (n_cur)
  );

  kvni_normal_gen u_norm_nxt (
    .clk   (clk),
    .en    (en.s2),
    .theta (r_nxt_th),
    .phi   (r_nxt_ph),
    .n     (n_nxt)
  );

  always_ff @(posedge clk) begin
    if (en.s2) begin
      c2_cur <= c1_cur;
      c2_nxt <= c1_nxt;
    end
  end

  // Stages 3 and 4: weight products, then sums with floor / rounding.
  kvni_blend u_blend (
    .clk      (clk),
    .en       (en),
    .w        (w),
    .wc       (wc),
    .c_cur    (c2_cur),
    .c_nxt    (c2_nxt),
    .n_cur    (n_cur),
    .n_nxt    (n_nxt),
    .out_data (out_data)
  );

  // Weight stays clamped and its complement consistent.
  `KVNI_ASSERT_NOW(a_weight_pair, clk, rst, 1'b1,
    (w <= kvni_pkg::ONE_Q16) && (17'(w + wc) == kvni_pkg::ONE_Q16),
    "blend weight out of range or complement mismatch")

  // Back-pressure only when every stage is full and the output is held.
  `KVNI_ASSERT_NOW(a_stall_full, clk, rst, in_stall,
    v1 && v2 && v3 && v4 && out_stall,
    "input stalled while pipeline has room")

  // An accepted transaction lands in stage 1.
  `KVNI_ASSERT_NEXT(a_accept_s1, clk, rst, in_valid && !in_stall, v1,
    "accepted transaction lost at stage 1")

endmodule

`default_nettype wire
